// ===== hdl/wed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wed_pkg
// Shared types and constants of the weighted six-operation edit distance block.
// ----------------------------------------------------------------------------
package wed_pkg;

  localparam int MAX_LEN    = 64;
  localparam int CHAR_BITS  = 8;
  localparam int COST_W     = 16;
  localparam int CFG_W      = 8;
  localparam int REG_IDX_W  = 3;
  localparam int IDX_W      = $clog2(MAX_LEN + 1);
  localparam int SADDR_W    = $clog2(MAX_LEN);
  localparam int COL_DEPTH  = MAX_LEN + 1;

  localparam logic OP_SOURCE = 1'b0;
  localparam logic OP_TARGET = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_INSERT  = 3'd0,
    REG_COPY    = 3'd1,
    REG_DELETE  = 3'd2,
    REG_REPLACE = 3'd3,
    REG_TWIDDLE = 3'd4,
    REG_KILL    = 3'd5
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ADV_RD,
    ST_ADV_INS,
    ST_ADV_DEL,
    ST_ADV_DIA,
    ST_ADV_TWI,
    ST_ADV_WR,
    ST_FIN_RD,
    ST_FIN_LAST,
    ST_KILL_RD,
    ST_KILL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [COST_W-1:0] base;
    logic [CFG_W-1:0]  addend;
    logic [COST_W-1:0] best;
    logic              first;
  } alu_req_t;

  typedef struct packed {
    logic [COST_W-1:0] sum;
    logic              ovf;
    logic [COST_W-1:0] best;
  } alu_res_t;

endpackage : wed_pkg
`default_nettype wire

// ===== hdl/wed_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wed_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module wed_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule : wed_ram
`default_nettype wire

// ===== hdl/wed_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wed_alu
// Shared saturating cost adder with a running minimum compare.
// ----------------------------------------------------------------------------
module wed_alu
  import wed_pkg::*;
(
  input  alu_req_t req,
  output alu_res_t res
);

  logic [COST_W:0] sum_wide;

  always_comb begin
    sum_wide = {1'b0, req.base} + {{(COST_W + 1 - CFG_W){1'b0}}, req.addend};
    res.ovf  = sum_wide[COST_W];
    res.sum  = res.ovf ? {COST_W{1'b1}} : sum_wide[COST_W-1:0];
    res.best = (req.first || (res.sum < req.best)) ? res.sum : req.best;
  end

endmodule : wed_alu
`default_nettype wire

// ===== hdl/weighted_edit_distance_six_ops.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_edit_distance_six_ops
// Weighted edit distance with copy, replace, insert, delete, twiddle and kill.
// ----------------------------------------------------------------------------
// A source request never raises busy. A target request raises busy while one
// shared saturating adder walks the cost column of the stored source length
// L: the first character of a target builds the starting column, each
// character reads, adds and writes every row (insert only for row zero;
// insert, delete, diagonal and, when a twiddle applies, twiddle otherwise),
// and the final character searches the kill candidates and presents the
// result. The result is on out_distance and out_saturated for one cycle with
// out_valid high and must be captured then; it cannot be stalled.
// ----------------------------------------------------------------------------
module weighted_edit_distance_six_ops
  import wed_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [CHAR_BITS-1:0] in_symbol,
  input  logic                 in_has_symbol,
  input  logic                 in_last,
  output logic                 out_valid,
  output logic [COST_W-1:0]    out_distance,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] cost_insert_r, cost_copy_r, cost_delete_r;
  logic [CFG_W-1:0] cost_replace_r, cost_twiddle_r, cost_kill_r;

  logic [IDX_W-1:0]     len_r;
  logic                 closed_r;
  logic                 target_active_r;
  logic                 overflow_r;
  logic                 sel_r;
  logic [CHAR_BITS-1:0] prev_char_r;

  logic [CHAR_BITS-1:0] sym_r;
  logic                 has_r;
  logic                 last_r;
  logic [IDX_W-1:0]     idx_r;
  logic [COST_W-1:0]    acc_r;
  logic [COST_W-1:0]    best_r;
  logic [COST_W-1:0]    cur_im1_r;
  logic [COST_W-1:0]    old_im1_r;
  logic [COST_W-1:0]    old_im2_r;
  logic [COST_W-1:0]    fresh_im1_r;
  logic [CHAR_BITS-1:0] src_im2_r;

  logic accept, src_accept, tgt_accept;
  logic [IDX_W-1:0] base_len;

  logic                 src_we, src_re;
  logic [SADDR_W-1:0]   src_wa, src_ra;
  logic [CHAR_BITS-1:0] src_rd;

  logic               col_we, col_wbank, col_re;
  logic [IDX_W-1:0]   col_wa, col_ra;
  logic [COST_W-1:0]  col_wd;
  logic [COST_W-1:0]  bank0_rd, bank1_rd;
  logic [COST_W-1:0]  cur_rd, old_rd;

  alu_req_t alu_req;
  alu_res_t alu_res;
  logic     ovf_en;
  logic     twi_ok;

  assign accept     = start && !busy;
  assign src_accept = accept && (in_op == OP_SOURCE);
  assign tgt_accept = accept && (in_op == OP_TARGET);
  assign base_len   = closed_r ? '0 : len_r;
  assign cfg_ready  = 1'b1;

  assign src_we = src_accept && in_has_symbol && (base_len < IDX_W'(MAX_LEN));
  assign src_wa = base_len[SADDR_W-1:0];

  assign cur_rd = sel_r ? bank1_rd : bank0_rd;
  assign old_rd = sel_r ? bank0_rd : bank1_rd;

  assign twi_ok = target_active_r && (idx_r >= IDX_W'(2)) &&
                  (src_rd == prev_char_r) && (src_im2_r == sym_r);

  wed_ram #(.WIDTH(CHAR_BITS), .DEPTH(MAX_LEN)) u_src_ram (
    .clk     (clk),
    .we      (src_we),
    .wr_addr (src_wa),
    .wr_data (in_symbol),
    .re      (src_re),
    .rd_addr (src_ra),
    .rd_data (src_rd)
  );

  wed_ram #(.WIDTH(COST_W), .DEPTH(COL_DEPTH)) u_col_ram0 (
    .clk     (clk),
    .we      (col_we && !col_wbank),
    .wr_addr (col_wa),
    .wr_data (col_wd),
    .re      (col_re),
    .rd_addr (col_ra),
    .rd_data (bank0_rd)
  );

  wed_ram #(.WIDTH(COST_W), .DEPTH(COL_DEPTH)) u_col_ram1 (
    .clk     (clk),
    .we      (col_we && col_wbank),
    .wr_addr (col_wa),
    .wr_data (col_wd),
    .re      (col_re),
    .rd_addr (col_ra),
    .rd_data (bank1_rd)
  );

  wed_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (tgt_accept) begin
          if (!target_active_r) begin
            state_nxt = ST_INIT;
          end else if (in_has_symbol) begin
            state_nxt = ST_ADV_RD;
          end else begin
            state_nxt = ST_FIN_RD;
          end
        end
      end
      ST_INIT: begin
        if (idx_r == len_r) begin
          state_nxt = has_r ? ST_ADV_RD : ST_FIN_RD;
        end
      end
      ST_ADV_RD:  state_nxt = ST_ADV_INS;
      ST_ADV_INS: state_nxt = (idx_r == '0) ? ST_ADV_WR : ST_ADV_DEL;
      ST_ADV_DEL: state_nxt = ST_ADV_DIA;
      ST_ADV_DIA: state_nxt = twi_ok ? ST_ADV_TWI : ST_ADV_WR;
      ST_ADV_TWI: state_nxt = ST_ADV_WR;
      ST_ADV_WR: begin
        if (idx_r == len_r) begin
          state_nxt = last_r ? ST_FIN_RD : ST_IDLE;
        end else begin
          state_nxt = ST_ADV_RD;
        end
      end
      ST_FIN_RD:   state_nxt = ST_FIN_LAST;
      ST_FIN_LAST: state_nxt = (len_r == '0) ? ST_EMIT : ST_KILL_RD;
      ST_KILL_RD:  state_nxt = ST_KILL;
      ST_KILL:     state_nxt = (idx_r == len_r - IDX_W'(1)) ? ST_EMIT : ST_KILL_RD;
      ST_EMIT:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath control.
  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT);
    src_re    = 1'b0;
    src_ra    = SADDR_W'(idx_r - IDX_W'(1));
    col_re    = 1'b0;
    col_ra    = idx_r;
    col_we    = 1'b0;
    col_wbank = sel_r;
    col_wa    = idx_r;
    col_wd    = best_r;
    ovf_en    = 1'b0;
    alu_req   = '{base: '0, addend: '0, best: best_r, first: 1'b1};
    case (state_r)
      ST_INIT: begin
        alu_req.base   = acc_r;
        alu_req.addend = cost_delete_r;
        col_we         = 1'b1;
        col_wd         = (idx_r == '0) ? '0 : alu_res.sum;
        ovf_en         = (idx_r != '0);
      end
      ST_ADV_RD: begin
        src_re = 1'b1;
        col_re = 1'b1;
      end
      ST_ADV_INS: begin
        alu_req.base   = cur_rd;
        alu_req.addend = cost_insert_r;
        ovf_en         = 1'b1;
      end
      ST_ADV_DEL: begin
        alu_req.base   = fresh_im1_r;
        alu_req.addend = cost_delete_r;
        alu_req.first  = 1'b0;
        ovf_en         = 1'b1;
      end
      ST_ADV_DIA: begin
        alu_req.base   = cur_im1_r;
        alu_req.addend = (src_rd == sym_r) ? cost_copy_r : cost_replace_r;
        alu_req.first  = 1'b0;
        ovf_en         = 1'b1;
      end
      ST_ADV_TWI: begin
        alu_req.base   = old_im2_r;
        alu_req.addend = cost_twiddle_r;
        alu_req.first  = 1'b0;
        ovf_en         = 1'b1;
      end
      ST_ADV_WR: begin
        col_we    = 1'b1;
        col_wbank = !sel_r;
      end
      ST_FIN_RD: begin
        col_re = 1'b1;
        col_ra = len_r;
      end
      ST_KILL_RD: begin
        col_re = 1'b1;
      end
      ST_KILL: begin
        alu_req.base   = cur_rd;
        alu_req.addend = cost_kill_r;
        alu_req.first  = 1'b0;
        ovf_en         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_distance  = best_r;
  assign out_saturated = overflow_r;

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      cost_insert_r   <= 8'd1;
      cost_copy_r     <= 8'd0;
      cost_delete_r   <= 8'd1;
      cost_replace_r  <= 8'd1;
      cost_twiddle_r  <= 8'd1;
      cost_kill_r     <= 8'd255;
      len_r           <= '0;
      closed_r        <= 1'b0;
      target_active_r <= 1'b0;
      overflow_r      <= 1'b0;
      sel_r           <= 1'b0;
      prev_char_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INSERT:  cost_insert_r  <= cfg_data;
          REG_COPY:    cost_copy_r    <= cfg_data;
          REG_DELETE:  cost_delete_r  <= cfg_data;
          REG_REPLACE: cost_replace_r <= cfg_data;
          REG_TWIDDLE: cost_twiddle_r <= cfg_data;
          REG_KILL:    cost_kill_r    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (src_accept) begin
        target_active_r <= 1'b0;
        if (!in_has_symbol) begin
          len_r    <= '0;
          closed_r <= 1'b1;
        end else begin
          len_r    <= src_we ? base_len + IDX_W'(1) : base_len;
          closed_r <= in_last;
        end
      end
      if (tgt_accept) begin
        closed_r <= 1'b1;
        if (!target_active_r) begin
          overflow_r <= 1'b0;
        end
      end else if (ovf_en && alu_res.ovf) begin
        overflow_r <= 1'b1;
      end
      if ((state_r == ST_ADV_WR) && (idx_r == len_r)) begin
        sel_r           <= !sel_r;
        prev_char_r     <= sym_r;
        target_active_r <= 1'b1;
      end
      if (state_r == ST_EMIT) begin
        target_active_r <= 1'b0;
      end
    end
  end

  // Column sweep datapath.
  always_ff @(posedge clk) begin
    if (tgt_accept) begin
      sym_r  <= in_symbol;
      has_r  <= in_has_symbol;
      last_r <= in_last;
      idx_r  <= '0;
    end
    case (state_r)
      ST_INIT: begin
        acc_r <= (idx_r == '0) ? '0 : alu_res.sum;
        idx_r <= (idx_r == len_r) ? '0 : idx_r + IDX_W'(1);
      end
      ST_ADV_INS, ST_ADV_DEL, ST_ADV_DIA, ST_ADV_TWI: begin
        best_r <= alu_res.best;
      end
      ST_ADV_WR: begin
        cur_im1_r   <= cur_rd;
        old_im1_r   <= old_rd;
        old_im2_r   <= old_im1_r;
        src_im2_r   <= src_rd;
        fresh_im1_r <= best_r;
        idx_r       <= (idx_r == len_r) ? '0 : idx_r + IDX_W'(1);
      end
      ST_FIN_LAST: begin
        best_r <= cur_rd;
        idx_r  <= '0;
      end
      ST_KILL: begin
        best_r <= alu_res.best;
        idx_r  <= idx_r + IDX_W'(1);
      end
      default: begin
      end
    endcase
  end

endmodule : weighted_edit_distance_six_ops
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the weighted six-operation edit distance block.
// A short scripted run at the reset costs is followed by phases of random
// source and target strings, each phase with freshly written costs. An
// in-bench column model predicts every distance and saturation flag but for
// fixed script rows; each strobe is checked against the oldest expectation.
// ----------------------------------------------------------------------------
module tb;
  import wed_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 5_000_000;
  localparam int unsigned ITEM_BUDGET   = 1350;
  localparam int unsigned SETTLE_CYCLES = 10 * MAX_LEN + 32;
  localparam int unsigned NUM_REGS      = 6;
  localparam int unsigned COUNT_TOP     = 127;

  typedef struct packed {
    logic                 op;
    logic [CHAR_BITS-1:0] symbol;
    logic                 has_symbol;
    logic                 last;
  } request_t;

  typedef struct packed {
    logic [COST_W-1:0] distance;
    logic              saturated;
  } distance_t;

  typedef struct packed {
    request_t  req;
    logic      fixed;
    distance_t result;
  } script_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_op = OP_SOURCE;
  logic [CHAR_BITS-1:0] in_symbol = '0;
  logic                 in_has_symbol = 1'b0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic [COST_W-1:0]    out_distance;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  cfg_reg_t             cfg_index = REG_INSERT;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [CFG_W-1:0]     cost_reg [NUM_REGS];
  logic [CHAR_BITS-1:0] src_sym [MAX_LEN];
  int unsigned          src_len;
  logic [COST_W-1:0]    col_now [COL_DEPTH];
  logic [COST_W-1:0]    col_old [COL_DEPTH];
  logic [CHAR_BITS-1:0] prev_tsym;
  int unsigned          tgt_count;
  bit                   cost_ovf;
  bit                   src_closed;

  distance_t            pending [$];
  int unsigned          fail_count = 0;
  int unsigned          cycle_count = 0;
  int unsigned          items_sent = 0;
  bit                   no_idle = 1'b0;

  script_row_t script [23] = '{
    '{'{OP_TARGET, 8'hA5, 1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'hFF, 1'b1, 1'b1}, 1'b1, '{16'd1, 1'b0}},
    '{'{OP_SOURCE, 8'h00, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'hFF, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'hFF, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h00, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h3C, 1'b0, 1'b0}, 1'b1, '{16'd2, 1'b0}},
    '{'{OP_TARGET, 8'h00, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h41, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h42, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h42, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h43, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h7E, 1'b0, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h01, 1'b1, 1'b1}, 1'b1, '{16'd1, 1'b0}},
    '{'{OP_SOURCE, 8'h80, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h01, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_SOURCE, 8'h80, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h01, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h80, 1'b1, 1'b0}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h80, 1'b1, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'hC3, 1'b0, 1'b1}, 1'b1, '{16'd3, 1'b0}},
    '{'{OP_SOURCE, 8'h5A, 1'b0, 1'b1}, 1'b0, '{16'd0, 1'b0}},
    '{'{OP_TARGET, 8'h00, 1'b0, 1'b1}, 1'b1, '{16'd0, 1'b0}}
  };

  weighted_edit_distance_six_ops uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_symbol     (in_symbol),
    .in_has_symbol (in_has_symbol),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_distance  (out_distance),
    .out_saturated (out_saturated),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [COST_W-1:0] sat_sum(input logic [COST_W-1:0] a,
                                                input logic [CFG_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - CFG_W){1'b0}}, b};
    if (s[COST_W]) begin
      cost_ovf = 1'b1;
      return '1;
    end
    return s[COST_W-1:0];
  endfunction

  function automatic void clear_edit_state();
    int i;
    cost_reg[REG_INSERT]  = 8'd1;
    cost_reg[REG_COPY]    = 8'd0;
    cost_reg[REG_DELETE]  = 8'd1;
    cost_reg[REG_REPLACE] = 8'd1;
    cost_reg[REG_TWIDDLE] = 8'd1;
    cost_reg[REG_KILL]    = 8'd255;
    for (i = 0; i < MAX_LEN; i++) src_sym[i] = '0;
    for (i = 0; i < COL_DEPTH; i++) begin
      col_now[i] = '0;
      col_old[i] = '0;
    end
    src_len    = 0;
    prev_tsym  = '0;
    tgt_count  = 0;
    cost_ovf   = 1'b0;
    src_closed = 1'b0;
  endfunction

  function automatic void open_target();
    int unsigned i;
    cost_ovf   = 1'b0;
    col_now[0] = '0;
    for (i = 1; i <= src_len; i++) col_now[i] = sat_sum(col_now[i-1], cost_reg[REG_DELETE]);
  endfunction

  function automatic void advance_column(input logic [CHAR_BITS-1:0] b);
    logic [COST_W-1:0]    fresh [COL_DEPTH];
    logic [COST_W-1:0]    best;
    logic [COST_W-1:0]    cand;
    logic [CHAR_BITS-1:0] a;
    int unsigned          i;
    bit                   deep;
    deep = (tgt_count >= 1);
    for (i = 0; i < COL_DEPTH; i++) fresh[i] = col_now[i];
    fresh[0] = sat_sum(col_now[0], cost_reg[REG_INSERT]);
    for (i = 1; i <= src_len; i++) begin
      a    = src_sym[i-1];
      best = sat_sum(col_now[i], cost_reg[REG_INSERT]);
      cand = sat_sum(fresh[i-1], cost_reg[REG_DELETE]);
      if (cand < best) best = cand;
      cand = sat_sum(col_now[i-1], (a == b) ? cost_reg[REG_COPY] : cost_reg[REG_REPLACE]);
      if (cand < best) best = cand;
      if (deep && i >= 2 && a == prev_tsym && src_sym[i-2] == b) begin
        cand = sat_sum(col_old[i-2], cost_reg[REG_TWIDDLE]);
        if (cand < best) best = cand;
      end
      fresh[i] = best;
    end
    col_old   = col_now;
    col_now   = fresh;
    prev_tsym = b;
  endfunction

  function automatic logic [COST_W-1:0] best_total();
    logic [COST_W-1:0] best;
    logic [COST_W-1:0] cand;
    int unsigned       i;
    best = col_now[src_len];
    for (i = 0; i < src_len; i++) begin
      cand = sat_sum(col_now[i], cost_reg[REG_KILL]);
      if (cand < best) best = cand;
    end
    return best;
  endfunction

  function automatic void predict_distance(input request_t r, output bit got,
                                           output distance_t res);
    got = 1'b0;
    res = '0;
    if (r.op == OP_SOURCE) begin
      if (src_closed) begin
        src_len    = 0;
        src_closed = 1'b0;
      end
      tgt_count = 0;
      if (!r.has_symbol) begin
        src_len    = 0;
        src_closed = 1'b1;
        return;
      end
      if (src_len < MAX_LEN) begin
        src_sym[src_len] = r.symbol;
        src_len++;
      end
      if (r.last) src_closed = 1'b1;
      return;
    end
    src_closed = 1'b1;
    if (tgt_count == 0) open_target();
    if (r.has_symbol) begin
      advance_column(r.symbol);
      if (tgt_count < COUNT_TOP) tgt_count++;
    end
    if (!r.has_symbol || r.last) begin
      res.distance  = best_total();
      res.saturated = cost_ovf;
      tgt_count     = 0;
      got           = 1'b1;
    end
  endfunction

  function automatic int unsigned idle_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_W-1:0] pick_cost(input int unsigned phase);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (phase == 0) return '0;
    if (phase <= 2) return '1;
    if (r < 15) return '0;
    if (r < 30) return '1;
    if (r < 60) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(0, 255));
  endfunction

  task automatic issue(input request_t r, input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_op         <= r.op;
    in_symbol     <= r.symbol;
    in_has_symbol <= r.has_symbol;
    in_last       <= r.last;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic apply(input request_t r, input logic fixed = 1'b0,
                       input distance_t typed = '0);
    bit        got;
    distance_t calc;
    issue(r, idle_gap());
    predict_distance(r, got, calc);
    if (got) pending.push_back(fixed ? typed : calc);
  endtask

  task automatic load_costs(input logic [CFG_W-1:0] vals [NUM_REGS]);
    int k;
    cfg_valid <= 1'b1;
    for (k = 0; k < NUM_REGS; k++) begin
      cfg_index <= cfg_reg_t'(k);
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      cost_reg[k] = vals[k];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_sequence(input bit long_target);
    logic [CHAR_BITS-1:0] base;
    logic [CHAR_BITS-1:0] tmp;
    logic [CHAR_BITS-1:0] word [$];
    logic [CHAR_BITS-1:0] tword [$];
    int unsigned          spread, slen, tcount, tlen, edits, pos, r, k, t;
    bit                   open_end, abandon, has0_end;
    request_t             req;

    base   = CHAR_BITS'($urandom_range(0, 255));
    spread = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : 255;
    r      = $urandom_range(0, 99);
    if (long_target) slen = $urandom_range(1, 3);
    else if (r < 8) slen = 0;
    else if (r < 75) slen = $urandom_range(1, 8);
    else if (r < 94) slen = $urandom_range(9, 24);
    else slen = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
    open_end = ($urandom_range(0, 9) == 0);

    if ($urandom_range(0, 19) == 0) begin
      req = '{OP_SOURCE, CHAR_BITS'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))};
      apply(req);
    end
    if (slen == 0) begin
      req = '{OP_SOURCE, CHAR_BITS'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))};
      apply(req);
    end
    for (k = 0; k < slen; k++) begin
      tmp = base + CHAR_BITS'($urandom_range(0, spread));
      word.push_back(tmp);
      req = '{OP_SOURCE, tmp, 1'b1, (k == slen - 1) && !open_end};
      apply(req);
    end

    if (long_target) tcount = 1;
    else if (slen > 24) tcount = $urandom_range(1, 2);
    else tcount = $urandom_range(0, 3);
    for (t = 0; t < tcount; t++) begin
      tword.delete();
      if (long_target) begin
        tlen = $urandom_range(258, 300);
        for (k = 0; k < tlen; k++) tword.push_back(CHAR_BITS'($urandom_range(0, 255)));
      end else if (slen > 24 || $urandom_range(0, 6) == 0) begin
        tlen = $urandom_range(0, 4);
        for (k = 0; k < tlen; k++) tword.push_back(base + CHAR_BITS'($urandom_range(0, spread)));
      end else begin
        tword = word;
        edits = $urandom_range(0, 3);
        repeat (edits) begin
          case ($urandom_range(0, 3))
            0: begin
              if (tword.size() >= 2) begin
                pos          = $urandom_range(0, tword.size() - 2);
                tmp          = tword[pos];
                tword[pos]   = tword[pos+1];
                tword[pos+1] = tmp;
              end
            end
            1: begin
              if (tword.size() != 0) begin
                pos        = $urandom_range(0, tword.size() - 1);
                tword[pos] = base + CHAR_BITS'($urandom_range(0, spread));
              end
            end
            2: begin
              pos = $urandom_range(0, tword.size());
              tword.insert(pos, base + CHAR_BITS'($urandom_range(0, spread)));
            end
            default: begin
              if (tword.size() != 0) tword.delete($urandom_range(0, tword.size() - 1));
            end
          endcase
        end
      end

      abandon  = (t == tcount - 1) && (tword.size() != 0) && ($urandom_range(0, 11) == 0);
      has0_end = !abandon && ((tword.size() == 0) || ($urandom_range(0, 9) == 0));
      for (k = 0; k < tword.size(); k++) begin
        req = '{OP_TARGET, tword[k], 1'b1, (k == tword.size() - 1) && !abandon && !has0_end};
        apply(req);
      end
      if (has0_end) begin
        req = '{OP_TARGET, CHAR_BITS'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1))};
        apply(req);
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    distance_t want;
    if (rst_n && out_valid) begin
      if (pending.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: distance=%0d saturated=%0b", out_distance, out_saturated);
        end
      end else begin
        want = pending.pop_front();
        if (out_distance !== want.distance || out_saturated !== want.saturated) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display({"result error: expected distance=%0d saturated=%0b, ",
                      "got distance=%0d saturated=%0b"},
                     want.distance, want.saturated, out_distance, out_saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("weighted_edit_distance_six_ops: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned      phase, seqs, n;
    logic [CFG_W-1:0] costs [NUM_REGS];
    clear_edit_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (n = 0; n < $size(script); n++) begin
      apply(script[n].req, script[n].fixed, script[n].result);
    end
    phase = 0;
    while (items_sent < ITEM_BUDGET) begin
      settle();
      for (n = 0; n < NUM_REGS; n++) costs[n] = pick_cost(phase);
      load_costs(costs);
      no_idle = ($urandom_range(0, 3) == 0);
      if (phase == 2) run_sequence(1'b1);
      seqs = $urandom_range(3, 8);
      for (n = 0; n < seqs && items_sent < ITEM_BUDGET; n++) run_sequence(1'b0);
      phase++;
    end
    settle();
    if (fail_count == 0 && pending.size() == 0) begin
      $display("weighted_edit_distance_six_ops: match");
    end else begin
      $display("weighted_edit_distance_six_ops: mismatch");
    end
    $finish;
  end

endmodule
